### hdl/mcm_pkg.sv
// Shared types and constants for the multi-channel mailbox FIFO.
package mcm_pkg;

  localparam int CMD_W     = 3;
  localparam int CHAN_IN_W = 4;
  localparam int BYTE_W    = 8;
  localparam int CNT_OUT_W = 8;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APP_WRITE = 3'd0,
    CMD_DEV_READ  = 3'd1,
    CMD_DEV_WRITE = 3'd2,
    CMD_APP_READ  = 3'd3,
    CMD_QUERY     = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_PTR  = 2'd1,
    FSM_DATA = 2'd2
  } fsm_t;

  // Request to one queue: push or pop, never both.
  typedef struct packed {
    logic push;
    logic pop;
  } q_op_t;

  // Outcome of one queue operation.
  typedef struct packed {
    logic    ok;
    status_t status;
  } q_res_t;

endpackage

### hdl/multi_channel_mailbox_fifo_core.sv
// Top level of the multi-channel mailbox FIFO: pointer memory, data stores and control.
//
// Each channel owns two circular byte queues: to_device (application writes,
// device reads) and to_app (device writes, application reads). A queue keeps
// one slot empty, so it holds at most REGION_DEPTH - 1 words.
// Input channel: in_valid/in_ready carry command, channel and write_data.
// Output channel: out_valid/out_ready carry one result word per input word:
// read_data, accepted, status and both occupancies of the addressed channel.
// Channel numbers at or above CHANNELS wrap modulo CHANNELS.
// The accepting edge reads the channel's pointers, the pointer stage writes
// back the updated pointers and accesses the data store, and the data stage
// loads the output register once that register is free.
// A new word is accepted in the cycle the previous result is loaded into the
// output register, so the block takes no new word before the previous one
// has passed the pointer memory read and the data store read.
// Reset clears every per-channel valid bit at once, so all queues read as
// empty right after reset; no clearing pass is needed. Data stores are not
// cleared. When the receiver stalls, the finished result waits in the output
// register and the block holds the next word in its data stage until the
// output register frees up.
module multi_channel_mailbox_fifo_core
  import mcm_pkg::*;
#(
  parameter int CHANNELS     = 16,
  parameter int REGION_DEPTH = 256,
  parameter int DATA_WIDTH   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [CHAN_IN_W-1:0] in_channel,
  input  logic [BYTE_W-1:0]    in_write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_read_data,
  output logic                 out_accepted,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CNT_OUT_W-1:0] out_to_device_count,
  output logic [CNT_OUT_W-1:0] out_to_app_count
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = $clog2(REGION_DEPTH);
  localparam int PM_W      = 4 * PTR_W;
  localparam int CHAN_IN_N = 1 << CHAN_IN_W;

  // Channel number folded into range; built at elaboration.
  logic [CH_W-1:0] chan_map [CHAN_IN_N];
  for (genvar g = 0; g < CHAN_IN_N; g++) begin : g_chan_map
    assign chan_map[g] = CH_W'(g % CHANNELS);
  end

  // Pointer memory: one word per channel holding
  // {to_device head, to_device tail, to_app head, to_app tail}.
  logic [PM_W-1:0]     ptr_mem [CHANNELS];
  logic [PM_W-1:0]     ptr_rd_r;
  logic [CHANNELS-1:0] pvalid_r;
  logic [CHANNELS-1:0] pvalid_nxt;

  // Data stores.
  logic [DATA_WIDTH-1:0] td_mem [CHANNELS][REGION_DEPTH];
  logic [DATA_WIDTH-1:0] ta_mem [CHANNELS][REGION_DEPTH];
  logic [DATA_WIDTH-1:0] td_rd_r;
  logic [DATA_WIDTH-1:0] ta_rd_r;

  fsm_t state_r, state_nxt;

  logic              in_fire;
  logic              out_load;
  logic [CH_W-1:0]   ch_in;
  logic [CH_W-1:0]   ch_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [BYTE_W-1:0] wdata_r;

  // Pointers of the current word; an invalid channel reads as all zero.
  logic [PM_W-1:0]  ptr_cur;
  logic [PTR_W-1:0] td_head, td_tail, ta_head, ta_tail;
  logic [PTR_W-1:0] td_head_nxt, td_tail_nxt, ta_head_nxt, ta_tail_nxt;
  logic [PTR_W-1:0] td_count, ta_count;
  q_op_t            td_op, ta_op;
  q_res_t           td_res, ta_res;

  logic [DATA_WIDTH+BYTE_W-1:0] wdata_ext;
  logic [DATA_WIDTH-1:0]        wdata_st;

  // Result held between the pointer stage and the output register.
  logic                  sel_td_r, sel_ta_r;
  logic                  acc_r;
  status_t               sts_r;
  logic [PTR_W-1:0]      td_cnt_r, ta_cnt_r;
  logic [DATA_WIDTH+BYTE_W-1:0] rd_ext;
  logic [PTR_W+CNT_OUT_W-1:0]   td_cnt_ext, ta_cnt_ext;

  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_rdata_r;
  logic                  out_acc_r;
  status_t               out_sts_r;
  logic [CNT_OUT_W-1:0]  out_td_cnt_r, out_ta_cnt_r;

  assign ch_in   = chan_map[in_channel];
  assign in_fire = in_valid && in_ready;

  // Control sequence.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = FSM_PTR;
        end
      end
      FSM_PTR: begin
        state_nxt = FSM_DATA;
      end
      FSM_DATA: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          in_ready  = 1'b1;
          state_nxt = in_valid ? FSM_PTR : FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the incoming word and read its channel's pointers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r     <= ch_in;
      cmd_r    <= in_command;
      wdata_r  <= in_write_data;
      ptr_rd_r <= ptr_mem[ch_in];
    end
  end

  assign ptr_cur = pvalid_r[ch_r] ? ptr_rd_r : '0;
  assign td_head = ptr_cur[4*PTR_W-1:3*PTR_W];
  assign td_tail = ptr_cur[3*PTR_W-1:2*PTR_W];
  assign ta_head = ptr_cur[2*PTR_W-1:PTR_W];
  assign ta_tail = ptr_cur[PTR_W-1:0];

  always_comb begin
    td_op.push = (cmd_r == CMD_APP_WRITE);
    td_op.pop  = (cmd_r == CMD_DEV_READ);
    ta_op.push = (cmd_r == CMD_DEV_WRITE);
    ta_op.pop  = (cmd_r == CMD_APP_READ);
  end

  mcm_queue_ctl #(
    .REGION_DEPTH (REGION_DEPTH),
    .PTR_W        (PTR_W)
  ) u_td_ctl (
    .head     (td_head),
    .tail     (td_tail),
    .op       (td_op),
    .head_nxt (td_head_nxt),
    .tail_nxt (td_tail_nxt),
    .res      (td_res),
    .count    (td_count)
  );

  mcm_queue_ctl #(
    .REGION_DEPTH (REGION_DEPTH),
    .PTR_W        (PTR_W)
  ) u_ta_ctl (
    .head     (ta_head),
    .tail     (ta_tail),
    .op       (ta_op),
    .head_nxt (ta_head_nxt),
    .tail_nxt (ta_tail_nxt),
    .res      (ta_res),
    .count    (ta_count)
  );

  // Write the updated pointers back in the pointer stage; the next word reads
  // them no earlier than the following cycle, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (state_r == FSM_PTR) begin
      ptr_mem[ch_r] <= {td_head_nxt, td_tail_nxt, ta_head_nxt, ta_tail_nxt};
    end
  end

  always_comb begin
    pvalid_nxt = pvalid_r;
    if (state_r == FSM_PTR) begin
      pvalid_nxt[ch_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= '0;
    end else begin
      pvalid_r <= pvalid_nxt;
    end
  end

  // Only the low DATA_WIDTH bits of the byte are stored.
  assign wdata_ext = {{DATA_WIDTH{1'b0}}, wdata_r};
  assign wdata_st  = wdata_ext[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (state_r == FSM_PTR && td_op.push && td_res.ok) begin
      td_mem[ch_r][td_tail] <= wdata_st;
    end
    if (state_r == FSM_PTR && td_op.pop && td_res.ok) begin
      td_rd_r <= td_mem[ch_r][td_head];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FSM_PTR && ta_op.push && ta_res.ok) begin
      ta_mem[ch_r][ta_tail] <= wdata_st;
    end
    if (state_r == FSM_PTR && ta_op.pop && ta_res.ok) begin
      ta_rd_r <= ta_mem[ch_r][ta_head];
    end
  end

  // Result fields other than read data are settled in the pointer stage.
  always_ff @(posedge clk) begin
    if (state_r == FSM_PTR) begin
      sel_td_r <= td_op.pop && td_res.ok;
      sel_ta_r <= ta_op.pop && ta_res.ok;
      acc_r    <= td_res.ok || ta_res.ok;
      sts_r    <= (td_res.status != STS_DONE) ? td_res.status : ta_res.status;
      td_cnt_r <= td_count;
      ta_cnt_r <= ta_count;
    end
  end

  always_comb begin
    if (sel_td_r) begin
      rd_ext = {{BYTE_W{1'b0}}, td_rd_r};
    end else if (sel_ta_r) begin
      rd_ext = {{BYTE_W{1'b0}}, ta_rd_r};
    end else begin
      rd_ext = '0;
    end
  end

  assign td_cnt_ext = {{CNT_OUT_W{1'b0}}, td_cnt_r};
  assign ta_cnt_ext = {{CNT_OUT_W{1'b0}}, ta_cnt_r};

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rdata_r  <= rd_ext[BYTE_W-1:0];
      out_acc_r    <= acc_r;
      out_sts_r    <= sts_r;
      out_td_cnt_r <= td_cnt_ext[CNT_OUT_W-1:0];
      out_ta_cnt_r <= ta_cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_rdata_r;
  assign out_accepted        = out_acc_r;
  assign out_status          = out_sts_r;
  assign out_to_device_count = out_td_cnt_r;
  assign out_to_app_count    = out_ta_cnt_r;

endmodule

### hdl/mcm_queue_ctl.sv
// Ring pointer update, full and empty checks and occupancy for one queue.
module mcm_queue_ctl
  import mcm_pkg::*;
#(
  parameter int REGION_DEPTH = 256,
  parameter int PTR_W        = 8
) (
  input  logic [PTR_W-1:0] head,
  input  logic [PTR_W-1:0] tail,
  input  q_op_t            op,
  output logic [PTR_W-1:0] head_nxt,
  output logic [PTR_W-1:0] tail_nxt,
  output q_res_t           res,
  output logic [PTR_W-1:0] count
);

  localparam logic [PTR_W-1:0] LAST  = PTR_W'(REGION_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH = (PTR_W+1)'(REGION_DEPTH);

  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W:0]   diff;
  logic [PTR_W:0]   diff_wrap;

  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;

  always_comb begin
    head_nxt   = head;
    tail_nxt   = tail;
    res.ok     = 1'b0;
    res.status = STS_DONE;
    if (op.push) begin
      if (tail_inc == head) begin
        res.status = STS_FULL;
      end else begin
        tail_nxt = tail_inc;
        res.ok   = 1'b1;
      end
    end else if (op.pop) begin
      if (head == tail) begin
        res.status = STS_EMPTY;
      end else begin
        head_nxt = head_inc;
        res.ok   = 1'b1;
      end
    end
  end

  // Occupancy after the update; a negative difference wraps by one depth.
  assign diff      = {1'b0, tail_nxt} - {1'b0, head_nxt};
  assign diff_wrap = diff[PTR_W] ? diff + DEPTH : diff;
  assign count     = diff_wrap[PTR_W-1:0];

endmodule

### hdl/mcm_checker.sv
// Port-level assertions for the multi-channel mailbox FIFO and their bind.
module mcm_checker
  import mcm_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BYTE_W-1:0]    out_read_data,
  input logic                 out_accepted,
  input logic [STATUS_W-1:0]  out_status,
  input logic [CNT_OUT_W-1:0] out_to_device_count,
  input logic [CNT_OUT_W-1:0] out_to_app_count
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_accepted) && $stable(out_status) &&
      $stable(out_to_device_count) && $stable(out_to_app_count))
    else $error("result word changed while stalled");

  // A moved word always reports done.
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_status == STS_DONE)
    else $error("accepted word with refusal status");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STS_DONE || out_status == STS_FULL ||
      out_status == STS_EMPTY)
    else $error("undefined status code");

  // Read data is zero unless a word was moved.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_read_data == '0)
    else $error("nonzero read data without a move");

endmodule

bind multi_channel_mailbox_fifo_core mcm_checker u_mcm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_read_data       (out_read_data),
  .out_accepted        (out_accepted),
  .out_status          (out_status),
  .out_to_device_count (out_to_device_count),
  .out_to_app_count    (out_to_app_count)
);

### tb/sv/tb.sv
// Self-checking testbench for the multi-channel mailbox FIFO core.
`timescale 1ns / 1ps

module tb;
  import mcm_pkg::*;

  // Command codes the block does not define; they must act as a plain query.
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  // Index of the two queues of a channel inside the shadow state.
  localparam int TO_DEV = 0;
  localparam int TO_APP = 1;

  localparam int RANDOM_WORDS = 1100;
  localparam int PHASE_LEN    = RANDOM_WORDS / 5;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 40;

  // One result word as the block presents it.
  typedef struct packed {
    logic [BYTE_W-1:0]    read_data;
    logic                 accepted;
    status_t              status;
    logic [CNT_OUT_W-1:0] dev_count;
    logic [CNT_OUT_W-1:0] app_count;
  } mbx_result_t;

  // One input word, plus a hand-written result when it is obvious.
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [CHAN_IN_W-1:0] ch;
    logic [BYTE_W-1:0]    data;
    logic                 typed;
    mbx_result_t          want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command;
  logic [CHAN_IN_W-1:0] in_channel;
  logic [BYTE_W-1:0]    in_write_data;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    out_read_data;
  logic                 out_accepted;
  logic [STATUS_W-1:0]  out_status;
  logic [CNT_OUT_W-1:0] out_to_device_count;
  logic [CNT_OUT_W-1:0] out_to_app_count;

  multi_channel_mailbox_fifo_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_channel          (in_channel),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_accepted        (out_accepted),
    .out_status          (out_status),
    .out_to_device_count (out_to_device_count),
    .out_to_app_count    (out_to_app_count)
  );

  // Shadow copy of every queue: byte rings plus read and write pointers per
  // channel. The 8-bit pointers wrap at 256, which is exactly the ring depth,
  // and the occupancy is simply the pointer difference in 8-bit arithmetic.
  logic [BYTE_W-1:0] ring_data [2][16][256];
  logic [7:0]        rd_ptr    [2][16];
  logic [7:0]        wr_ptr    [2][16];

  // Results the block still owes, oldest first.
  mbx_result_t pending_results [$];

  int  mismatches;
  int  cycle_count;
  int  sender_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;

  // Directed words, issued right after reset when every queue is empty.
  // Rows with typed set carry their result by hand; the rest are left to
  // the predictor. They cover both ends of the channel and data ranges, all
  // four moves, the query, the three undefined command codes, reads from an
  // empty queue, and write data that must be ignored by non-write commands.
  localparam int NUM_ROWS = 22;
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_QUERY,     4'd0,  8'h00, 1'b1, '{8'h00, 1'b0, STS_DONE,  8'd0, 8'd0}},
    '{CMD_DEV_READ,  4'd0,  8'hFF, 1'b1, '{8'h00, 1'b0, STS_EMPTY, 8'd0, 8'd0}},
    '{CMD_APP_READ,  4'd15, 8'h00, 1'b1, '{8'h00, 1'b0, STS_EMPTY, 8'd0, 8'd0}},
    '{CMD_APP_WRITE, 4'd0,  8'hFF, 1'b1, '{8'h00, 1'b1, STS_DONE,  8'd1, 8'd0}},
    '{CMD_APP_WRITE, 4'd15, 8'h00, 1'b1, '{8'h00, 1'b1, STS_DONE,  8'd1, 8'd0}},
    '{CMD_DEV_WRITE, 4'd0,  8'hA5, 1'b1, '{8'h00, 1'b1, STS_DONE,  8'd1, 8'd1}},
    '{CMD_DEV_WRITE, 4'd15, 8'h5A, 1'b1, '{8'h00, 1'b1, STS_DONE,  8'd1, 8'd1}},
    '{CMD_RSVD5,     4'd0,  8'hFF, 1'b1, '{8'h00, 1'b0, STS_DONE,  8'd1, 8'd1}},
    '{CMD_RSVD6,     4'd15, 8'hFF, 1'b1, '{8'h00, 1'b0, STS_DONE,  8'd1, 8'd1}},
    '{CMD_RSVD7,     4'd0,  8'h00, 1'b1, '{8'h00, 1'b0, STS_DONE,  8'd1, 8'd1}},
    '{CMD_QUERY,     4'd7,  8'hFF, 1'b1, '{8'h00, 1'b0, STS_DONE,  8'd0, 8'd0}},
    '{CMD_DEV_READ,  4'd0,  8'h00, 1'b1, '{8'hFF, 1'b1, STS_DONE,  8'd0, 8'd1}},
    '{CMD_APP_READ,  4'd0,  8'h00, 1'b1, '{8'hA5, 1'b1, STS_DONE,  8'd0, 8'd0}},
    '{CMD_DEV_READ,  4'd15, 8'hFF, 1'b1, '{8'h00, 1'b1, STS_DONE,  8'd0, 8'd1}},
    '{CMD_APP_READ,  4'd15, 8'hFF, 1'b1, '{8'h5A, 1'b1, STS_DONE,  8'd0, 8'd0}},
    '{CMD_DEV_READ,  4'd15, 8'h00, 1'b1, '{8'h00, 1'b0, STS_EMPTY, 8'd0, 8'd0}},
    '{CMD_APP_WRITE, 4'd8,  8'h55, 1'b0, '0},
    '{CMD_APP_WRITE, 4'd8,  8'hAA, 1'b0, '0},
    '{CMD_DEV_WRITE, 4'd8,  8'h0F, 1'b0, '0},
    '{CMD_DEV_READ,  4'd8,  8'h00, 1'b0, '0},
    '{CMD_APP_READ,  4'd8,  8'hF0, 1'b0, '0},
    '{CMD_QUERY,     4'd8,  8'h00, 1'b0, '0}
  };

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run guard: a stuck handshake or a missing result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multi_channel_mailbox_fifo_core verification failed");
      $finish;
    end
  end

  // Text form of one result word for mismatch reports.
  function automatic string result_text(mbx_result_t r);
    return $sformatf("rd=%02h acc=%0d st=%0d dev=%0d app=%0d", r.read_data,
                     r.accepted, r.status, r.dev_count, r.app_count);
  endfunction

  // Applies one word to the shadow queues and returns the result the block
  // must give for it. A write is refused when advancing the write pointer
  // would land on the read pointer; a read is refused when they are equal.
  // Undefined command codes fall through to the query behavior.
  function automatic mbx_result_t mailbox_step(logic [CMD_W-1:0] cmd,
                                               logic [CHAN_IN_W-1:0] ch,
                                               logic [BYTE_W-1:0] data);
    mbx_result_t res;
    int          q;
    logic        is_write;
    logic        is_read;
    logic [7:0]  next_wr;
    res      = '0;
    q        = TO_DEV;
    is_write = 1'b0;
    is_read  = 1'b0;
    case (cmd)
      CMD_APP_WRITE: begin
        q        = TO_DEV;
        is_write = 1'b1;
      end
      CMD_DEV_READ: begin
        q       = TO_DEV;
        is_read = 1'b1;
      end
      CMD_DEV_WRITE: begin
        q        = TO_APP;
        is_write = 1'b1;
      end
      CMD_APP_READ: begin
        q       = TO_APP;
        is_read = 1'b1;
      end
      default: begin
      end
    endcase
    next_wr = wr_ptr[q][ch] + 8'd1;
    if (is_write) begin
      if (next_wr == rd_ptr[q][ch]) begin
        res.status = STS_FULL;
      end else begin
        ring_data[q][ch][wr_ptr[q][ch]] = data;
        wr_ptr[q][ch] = next_wr;
        res.accepted  = 1'b1;
      end
    end else if (is_read) begin
      if (rd_ptr[q][ch] == wr_ptr[q][ch]) begin
        res.status = STS_EMPTY;
      end else begin
        res.read_data = ring_data[q][ch][rd_ptr[q][ch]];
        rd_ptr[q][ch] = rd_ptr[q][ch] + 8'd1;
        res.accepted  = 1'b1;
      end
    end
    res.dev_count = wr_ptr[TO_DEV][ch] - rd_ptr[TO_DEV][ch];
    res.app_count = wr_ptr[TO_APP][ch] - rd_ptr[TO_APP][ch];
    return res;
  endfunction

  // Offers one word, starting and ending at a falling edge. An optional run
  // of idle cycles goes first; then valid rises and stays up with a fixed
  // payload until the block takes the word. The expectation is queued at
  // the rising edge that accepts it.
  task automatic send_word(stim_row_t row);
    int          gap;
    mbx_result_t predicted;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= row.cmd;
    in_channel    <= row.ch;
    in_write_data <= row.data;
    do @(posedge clk); while (!in_ready);
    predicted = mailbox_step(row.cmd, row.ch, row.data);
    pending_results.push_back(row.typed ? row.want : predicted);
    @(negedge clk);
  endtask

  // Receiver. Stalls at random at the current rate, and once on request
  // holds off for a long stretch, counted here, so the sender runs into a
  // full pipeline and sees in_ready drop.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: every word taken from the block must match the oldest
  // outstanding expectation in every field.
  always @(posedge clk) begin
    mbx_result_t got;
    mbx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_read_data, out_accepted, status_t'(out_status),
              out_to_device_count, out_to_app_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result word with nothing expected: %s", $time,
                   result_text(got));
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: expected %s, actual %s", $time, result_text(want),
                     result_text(got));
          end
        end
      end
    end
  end

  // Main sequence: reset, the directed table, then the random traffic.
  //
  // Most random words follow a fill-and-drain pattern on one focus queue:
  // writes until the queue holds 255 bytes and two more writes bounce as
  // full, then reads until it is empty and one read bounces as empty. The
  // drain carries the read pointer around the ring so a later fill of the
  // same queue wraps the write pointer. After each round the focus moves to
  // the other queue direction on a random channel. The rest is unconstrained
  // noise over all commands, channels and data. The run steps through five
  // idle settings; the last one starts with the long receiver hold-off.
  initial begin
    stim_row_t            row;
    int                   focus_q;
    logic [CHAN_IN_W-1:0] focus_ch;
    bit                   filling;
    int                   overrun;
    logic [7:0]           occupancy;
    mismatches      = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_QUERY;
    in_channel      = '0;
    in_write_data   = '0;
    for (int q = 0; q < 2; q++) begin
      for (int c = 0; c < 16; c++) begin
        rd_ptr[q][c] = '0;
        wr_ptr[q][c] = '0;
      end
    end
    focus_q  = int'($urandom_range(1));
    focus_ch = CHAN_IN_W'($urandom_range(15));
    filling  = 1'b1;
    overrun  = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case (i / PHASE_LEN)
          0: begin
            sender_idle_pct = 0;
            recv_stall_pct  = 0;
          end
          1: begin
            sender_idle_pct = 57;
            recv_stall_pct  = 0;
          end
          2: begin
            sender_idle_pct = 0;
            recv_stall_pct  = 57;
          end
          3: begin
            sender_idle_pct = 6;
            recv_stall_pct  = 6;
          end
          default: begin
            sender_idle_pct = 0;
            recv_stall_pct  = 0;
            hold_req        = 1'b1;
          end
        endcase
      end
      row.typed = 1'b0;
      row.want  = '0;
      if ($urandom_range(99) < 15) begin
        row.cmd  = CMD_W'($urandom_range(7));
        row.ch   = CHAN_IN_W'($urandom_range(15));
        row.data = BYTE_W'($urandom_range(255));
      end else begin
        occupancy = wr_ptr[focus_q][focus_ch] - rd_ptr[focus_q][focus_ch];
        if (filling && occupancy == 8'd255) begin
          overrun++;
          if (overrun > 2) begin
            filling = 1'b0;
            overrun = 0;
          end
        end else if (!filling && occupancy == 8'd0) begin
          overrun++;
          if (overrun > 1) begin
            filling  = 1'b1;
            overrun  = 0;
            focus_q  = (focus_q == TO_DEV) ? TO_APP : TO_DEV;
            focus_ch = CHAN_IN_W'($urandom_range(15));
          end
        end
        row.ch   = focus_ch;
        row.data = BYTE_W'($urandom_range(255));
        if (filling) begin
          row.cmd = (focus_q == TO_DEV) ? CMD_APP_WRITE : CMD_DEV_WRITE;
        end else begin
          row.cmd = (focus_q == TO_DEV) ? CMD_DEV_READ : CMD_APP_READ;
        end
      end
      send_word(row);
    end

    // All words are in; let the outstanding results come back, then give
    // the block a few more cycles to show any result it should not produce.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_channel_mailbox_fifo_core verification clean");
    end else begin
      $display("multi_channel_mailbox_fifo_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/mcm_pkg.sv
hdl/mcm_queue_ctl.sv
hdl/multi_channel_mailbox_fifo_core.sv
hdl/mcm_checker.sv
tb/sv/tb.sv
